// ===== rtl/sla_pkg.sv =====
// ----------------------------------------------------------------------------
// sla_pkg
// Shared constants and controller/datapath interface types for the serial
// line assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package sla_pkg;

  localparam int unsigned LINE_CHARS_DEF = 64;

  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIMIT_W = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd64;

  localparam logic [BYTE_W-1:0] BYTE_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_BS  = 8'h08;
  localparam logic [BYTE_W-1:0] BYTE_DEL = 8'h7F;
  localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;

  typedef struct packed {
    logic edit_en;
    logic load_line;
    logic rd_en;
    logic step;
  } sla_cmd_t;

  typedef struct packed {
    logic emit_req;
    logic line_none;
    logic last_beat;
  } sla_sts_t;

endpackage

`default_nettype wire

// ===== rtl/sla_ctrl.sv =====
// ----------------------------------------------------------------------------
// sla_ctrl
// Sequencer: takes input beats while idle, then walks the emitted line one
// output beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module sla_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire sla_pkg::sla_sts_t sts_i,
  output sla_pkg::sla_cmd_t      cmd_o
);
  import sla_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_SHOW  = 3'b100
  } sla_state_e;

  sla_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.emit_req) begin
            cmd_o.load_line = 1'b1;
            state_d = sts_i.line_none ? ST_SHOW : ST_FETCH;
          end else begin
            cmd_o.edit_en = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_SHOW;
      end
      ST_SHOW: begin
        if (!out_stall_i) begin
          if (sts_i.last_beat) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.step  = 1'b1;
            cmd_o.rd_en = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_SHOW);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && !in_stall_o))
    else $error("output beat offered while input open");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHOW && !out_stall_i && sts_i.last_beat) |=> state_q == ST_IDLE)
    else $error("line did not end after last beat");

  a_fetch_show: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |=> state_q == ST_SHOW)
    else $error("fetch not followed by show");

endmodule

`default_nettype wire

// ===== rtl/sla_datapath.sv =====
// ----------------------------------------------------------------------------
// sla_datapath
// Line store, length and overflow tracking, output limit register and the
// read side that feeds the output beats.
// ----------------------------------------------------------------------------
`default_nettype none

module sla_datapath #(
  parameter int unsigned LINE_CHARS = sla_pkg::LINE_CHARS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sla_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  input  wire logic [sla_pkg::BYTE_W-1:0]    rx_byte_i,
  input  wire sla_pkg::sla_cmd_t             cmd_i,
  output sla_pkg::sla_sts_t                  sts_o,
  output logic                               char_valid_o,
  output logic [sla_pkg::CHAR_W-1:0]         character_o,
  output logic                               status_o
);
  import sla_pkg::*;

  localparam int unsigned LenW = $clog2(LINE_CHARS + 1);
  localparam int unsigned IdxW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
  localparam logic [LenW-1:0] LenMax = LenW'(LINE_CHARS);

  logic [CHAR_W-1:0]  mem_q [LINE_CHARS];
  logic [CHAR_W-1:0]  rd_data_q;
  logic [LenW-1:0]    len_q, len_d;
  logic               ovf_q, ovf_d;
  logic [LIMIT_W-1:0] limit_q;
  logic [LenW-1:0]    n_q;
  logic [IdxW-1:0]    k_q, k_d;
  logic               empty_q;
  logic               st_q;

  logic [LIMIT_W-1:0] len_ext;
  logic [LIMIT_W-1:0] n_wide;
  logic [LenW-1:0]    n_cur;
  logic               is_print;
  logic               is_erase;
  logic               wr_en;
  logic [IdxW-1:0]    rd_addr;

  assign len_ext  = LIMIT_W'(len_q);
  assign n_wide   = (len_ext > limit_q) ? limit_q : len_ext;
  assign n_cur    = LenW'(n_wide);
  assign is_print = (rx_byte_i >= PRINT_LO) && (rx_byte_i <= PRINT_HI);
  assign is_erase = (rx_byte_i == BYTE_BS) || (rx_byte_i == BYTE_DEL);
  assign wr_en    = cmd_i.edit_en && is_print && (len_q < LenMax);
  assign rd_addr  = cmd_i.step ? IdxW'(k_q + 1'b1) : k_q;

  assign sts_o.emit_req  = (rx_byte_i == BYTE_LF) && ((len_q != '0) || ovf_q);
  assign sts_o.line_none = (n_cur == '0);
  assign sts_o.last_beat = empty_q || ((LenW'(k_q) + LenW'(1)) == n_q);

  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    k_d   = k_q;
    if (cmd_i.load_line) begin
      len_d = '0;
      ovf_d = 1'b0;
      k_d   = '0;
    end else if (cmd_i.edit_en) begin
      if (is_erase) begin
        if (len_q != '0) begin
          len_d = len_q - LenW'(1);
        end
      end else if (is_print) begin
        if (len_q < LenMax) begin
          len_d = len_q + LenW'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
    end else if (cmd_i.step) begin
      k_d = IdxW'(k_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      ovf_q   <= 1'b0;
      limit_q <= LIMIT_RST;
      k_q     <= '0;
      n_q     <= '0;
      empty_q <= 1'b0;
      st_q    <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
      k_q   <= k_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.load_line) begin
        n_q     <= n_cur;
        empty_q <= (n_cur == '0);
        st_q    <= ovf_q;
      end
    end
  end

  // line store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[len_q[IdxW-1:0]] <= rx_byte_i[CHAR_W-1:0];
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign char_valid_o = !empty_q;
  assign character_o  = empty_q ? '0 : rd_data_q;
  assign status_o     = st_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenMax)
    else $error("line length beyond capacity");

  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_line |=> (len_q == '0) && !ovf_q)
    else $error("line not cleared on emission");

endmodule

`default_nettype wire

// ===== rtl/serial_line_assembler_core.sv =====
// ----------------------------------------------------------------------------
// serial_line_assembler_core
// Line editor for a received byte stream: stores printable characters,
// handles backspace/delete, and emits a line on line feed.
// ----------------------------------------------------------------------------
// input channel: one raw byte per beat (in_valid_i / in_stall_o / rx_byte_i)
// output channel: one character per beat with last_o on the line's final
//   beat and status_o set if the line overflowed; an empty line is one beat
//   with char_valid_o low
// cfg_we_i / cfg_wdata_i write the per-line character limit at any idle time
// an editing byte is applied as it is taken; the input stays open every cycle while editing
// a line feed that emits a line stalls the input until its last beat is
//   taken; the first beat follows the fetch state's line store read (an empty
//   line goes straight to the show state), then one beat per cycle from the
//   line store read port while the output does not stall
// a stalled output beat holds its value and pauses the line walk
// reset empties the line, clears overflow and sets the limit to 64; the
// line store itself is not cleared and needs no pass
// ----------------------------------------------------------------------------
`default_nettype none

module serial_line_assembler_core #(
  parameter int unsigned LINE_CHARS = sla_pkg::LINE_CHARS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sla_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [sla_pkg::BYTE_W-1:0]    rx_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               char_valid_o,
  output logic [sla_pkg::CHAR_W-1:0]         character_o,
  output logic                               last_o,
  output logic                               status_o
);
  import sla_pkg::*;

  sla_cmd_t cmd;
  sla_sts_t sts;

  sla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sla_datapath #(
    .LINE_CHARS (LINE_CHARS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rx_byte_i    (rx_byte_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .char_valid_o (char_valid_o),
    .character_o  (character_o),
    .status_o     (status_o)
  );

  assign last_o = sts.last_beat;

endmodule

`default_nettype wire
